// File: hw/rtl/gfr_pkg.sv
// Shared constants, types and the 5x7 font table for the glyph frame renderer.
package gfr_pkg;

  localparam int FRAME_WIDTH  = 200;
  localparam int FRAME_HEIGHT = 200;
  localparam int MAX_SCALE    = 8;

  localparam int ROW_BYTES   = (FRAME_WIDTH + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * FRAME_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int SCALE_W     = $clog2(MAX_SCALE + 1);
  // glyph origin plus up to seven dot pitches, with sign
  localparam int COORD_W     = 13;

  localparam int FONT_SLOTS   = 42;
  localparam int FONT_UNKNOWN = 41;
  localparam int GLYPH_COLS   = 5;
  localparam int GLYPH_ROWS   = 7;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_SET   = 2'd1,
    OP_DRAW  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DOT,
    ST_PIX,
    ST_WR,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                operation;
    logic signed [9:0]  x_pos;
    logic signed [9:0]  y_pos;
    logic               pixel_black;
    logic [7:0]         char_code;
    logic [3:0]         scale;
    logic [12:0]        byte_index;
  } item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // five column bytes, left to right; bit 0 is the top row
  typedef logic [0:4][7:0] glyph_t;

  localparam glyph_t FONT [FONT_SLOTS] = '{
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    {8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
    {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, {8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, {8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    {8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
    {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
    {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
    {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
    {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
    {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
    {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
    {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
    {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
    {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    {8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
    {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, {8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    {8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, {8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
    {8'h08, 8'h08, 8'h08, 8'h08, 8'h08}, {8'h00, 8'h60, 8'h60, 8'h00, 8'h00},
    {8'h00, 8'h36, 8'h36, 8'h00, 8'h00}, {8'h20, 8'h10, 8'h08, 8'h04, 8'h02},
    {8'h02, 8'h01, 8'h51, 8'h09, 8'h06}
  };

  // map an ASCII code to its font slot; lower case folds to upper case
  function automatic logic [5:0] font_slot(input logic [7:0] code);
    logic [7:0] c;
    logic [5:0] slot;
    c = code;
    if (c inside {[8'h61:8'h7A]}) c = c - 8'h20;
    if (c == 8'h20)                     slot = 6'd0;
    else if (c inside {[8'h30:8'h39]})  slot = 6'(c - 8'h30 + 8'd1);
    else if (c inside {[8'h41:8'h5A]})  slot = 6'(c - 8'h41 + 8'd11);
    else if (c == 8'h2D)                slot = 6'd37;
    else if (c == 8'h2E)                slot = 6'd38;
    else if (c == 8'h3A)                slot = 6'd39;
    else if (c == 8'h2F)                slot = 6'd40;
    else                                slot = 6'(FONT_UNKNOWN);
    return slot;
  endfunction

  function automatic glyph_t font_glyph(input logic [7:0] code);
    return FONT[font_slot(code)];
  endfunction

endpackage

// File: hw/rtl/gfr_frame_ram.sv
// Frame store: single write port, single registered read port.
module gfr_frame_ram (
  input  logic               clk,
  input  gfr_pkg::ram_req_t  req,
  output logic [7:0]         rdata
);

  logic [7:0] mem [gfr_pkg::STORE_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// File: hw/rtl/gfr_engine.sv
// Operation sequencer: clear sweep, pixel read-modify-write, glyph walk, byte read.
module gfr_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gfr_pkg::item_t                item,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [7:0]                    res_data,
  output gfr_pkg::ram_req_t             ram_req,
  input  logic [7:0]                    ram_rdata
);

  localparam int ADDR_W  = gfr_pkg::ADDR_W;
  localparam int SCALE_W = gfr_pkg::SCALE_W;
  localparam int COORD_W = gfr_pkg::COORD_W;

  gfr_pkg::state_t state, state_next;

  logic [ADDR_W-1:0]          clr_addr;
  logic                       clr_reply;
  logic                       black;
  logic                       single;
  logic [SCALE_W-1:0]         scale_q;
  gfr_pkg::glyph_t            glyph;
  logic [2:0]                 col;
  logic [2:0]                 row;
  logic [SCALE_W-1:0]         dx;
  logic [SCALE_W-1:0]         dy;
  logic signed [COORD_W-1:0]  colx;
  logic signed [COORD_W-1:0]  rowy;
  logic signed [COORD_W-1:0]  basey;
  logic [ADDR_W-1:0]          wr_addr;
  logic [7:0]                 wr_mask;

  logic                       take;
  logic                       clr_last;
  logic signed [COORD_W-1:0]  scale_ext, dx_ext, dy_ext, px, py;
  logic                       on_frame;
  logic [ADDR_W-1:0]          pix_addr;
  logic [7:0]                 pix_mask;
  logic                       last_dx, last_dy, dot_end, blk_end;
  logic                       read_hit;
  logic [SCALE_W-1:0]         scale_sat;
  gfr_pkg::state_t            adv_state;

  assign take      = in_valid && in_ready;
  assign clr_last  = clr_addr == ADDR_W'(gfr_pkg::STORE_BYTES - 1);
  assign scale_ext = $signed({{(COORD_W-SCALE_W){1'b0}}, scale_q});
  assign dx_ext    = $signed({{(COORD_W-SCALE_W){1'b0}}, dx});
  assign dy_ext    = $signed({{(COORD_W-SCALE_W){1'b0}}, dy});
  assign px        = colx + dx_ext;
  assign py        = rowy + dy_ext;
  assign on_frame  = (px >= 0) && (py >= 0) &&
                     (px < gfr_pkg::FRAME_WIDTH) && (py < gfr_pkg::FRAME_HEIGHT);
  assign pix_addr  = ADDR_W'($unsigned(py) * gfr_pkg::ROW_BYTES) +
                     ADDR_W'($unsigned(px) >> 3);
  assign pix_mask  = 8'h80 >> px[2:0];
  assign last_dx   = dx == SCALE_W'(scale_q - 1'b1);
  assign last_dy   = dy == SCALE_W'(scale_q - 1'b1);
  assign dot_end   = (row == 3'(gfr_pkg::GLYPH_ROWS - 1)) &&
                     (col == 3'(gfr_pkg::GLYPH_COLS - 1));
  assign blk_end   = last_dx && last_dy;
  assign read_hit  = 32'(item.byte_index) < gfr_pkg::STORE_BYTES;
  assign scale_sat = (32'(item.scale) > gfr_pkg::MAX_SCALE) ?
                     SCALE_W'(gfr_pkg::MAX_SCALE) : SCALE_W'(item.scale);

  // where to go once the current pixel is finished
  always_comb begin
    if (single)        adv_state = gfr_pkg::ST_DONE;
    else if (!blk_end) adv_state = gfr_pkg::ST_PIX;
    else if (dot_end)  adv_state = gfr_pkg::ST_DONE;
    else               adv_state = gfr_pkg::ST_DOT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gfr_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = wr_addr;
    ram_req.wdata = black ? (ram_rdata & ~wr_mask) : (ram_rdata | wr_mask);
    ram_req.raddr = pix_addr;
    case (state)
      gfr_pkg::ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_addr;
        ram_req.wdata = 8'hFF;
        if (clr_last) state_next = clr_reply ? gfr_pkg::ST_DONE : gfr_pkg::ST_IDLE;
      end
      gfr_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        ram_req.raddr = ADDR_W'(item.byte_index);
        if (in_valid) begin
          case (item.operation)
            gfr_pkg::OP_CLEAR: state_next = gfr_pkg::ST_CLEAR;
            gfr_pkg::OP_SET:   state_next = gfr_pkg::ST_PIX;
            gfr_pkg::OP_DRAW:  state_next = (scale_sat == '0) ? gfr_pkg::ST_DONE
                                                              : gfr_pkg::ST_DOT;
            gfr_pkg::OP_READ:  state_next = read_hit ? gfr_pkg::ST_READ
                                                     : gfr_pkg::ST_DONE;
            default:           state_next = gfr_pkg::ST_DONE;
          endcase
        end
      end
      gfr_pkg::ST_DOT: begin
        if (glyph[col][row])  state_next = gfr_pkg::ST_PIX;
        else if (dot_end)     state_next = gfr_pkg::ST_DONE;
      end
      gfr_pkg::ST_PIX: begin
        state_next = on_frame ? gfr_pkg::ST_WR : adv_state;
      end
      gfr_pkg::ST_WR: begin
        ram_req.we = 1'b1;
        state_next = adv_state;
      end
      gfr_pkg::ST_READ: begin
        state_next = gfr_pkg::ST_DONE;
      end
      gfr_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_next = gfr_pkg::ST_IDLE;
      end
      default: state_next = gfr_pkg::ST_IDLE;
    endcase
  end

  // clear sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      clr_reply <= 1'b0;
    end else if (state == gfr_pkg::ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end else if (take) begin
      clr_addr  <= '0;
      clr_reply <= 1'b1;
    end
  end

  // walk: dy fastest, then dx, then row, then column
  always_ff @(posedge clk) begin
    case (state)
      gfr_pkg::ST_IDLE: begin
        if (in_valid) begin
          black    <= (item.operation == gfr_pkg::OP_SET) ? item.pixel_black : 1'b1;
          single   <= item.operation == gfr_pkg::OP_SET;
          scale_q  <= scale_sat;
          glyph    <= gfr_pkg::font_glyph(item.char_code);
          col      <= '0;
          row      <= '0;
          dx       <= '0;
          dy       <= '0;
          colx     <= COORD_W'(item.x_pos);
          rowy     <= COORD_W'(item.y_pos);
          basey    <= COORD_W'(item.y_pos);
          res_data <= '0;
        end
      end
      gfr_pkg::ST_DOT: begin
        if (!glyph[col][row]) begin
          if (row == 3'(gfr_pkg::GLYPH_ROWS - 1)) begin
            row  <= '0;
            rowy <= basey;
            col  <= col + 1'b1;
            colx <= colx + scale_ext;
          end else begin
            row  <= row + 1'b1;
            rowy <= rowy + scale_ext;
          end
        end
      end
      gfr_pkg::ST_PIX, gfr_pkg::ST_WR: begin
        if (state == gfr_pkg::ST_PIX && on_frame) begin
          wr_addr <= pix_addr;
          wr_mask <= pix_mask;
        end else if (!last_dy) begin
          dy <= dy + 1'b1;
        end else begin
          dy <= '0;
          if (!last_dx) begin
            dx <= dx + 1'b1;
          end else begin
            dx <= '0;
            if (row == 3'(gfr_pkg::GLYPH_ROWS - 1)) begin
              row  <= '0;
              rowy <= basey;
              col  <= col + 1'b1;
              colx <= colx + scale_ext;
            end else begin
              row  <= row + 1'b1;
              rowy <= rowy + scale_ext;
            end
          end
        end
      end
      gfr_pkg::ST_READ: begin
        res_data <= ram_rdata;
      end
      default: begin
      end
    endcase
  end

  a_wr_follows_read: assert property (@(posedge clk) disable iff (rst)
    state == gfr_pkg::ST_WR |-> ram_req.waddr == $past(ram_req.raddr))
    else $error("write-back address differs from the address read");

  a_read_issue: assert property (@(posedge clk) disable iff (rst)
    take && item.operation == gfr_pkg::OP_READ && read_hit |=> state == gfr_pkg::ST_READ)
    else $error("in-range read did not enter read state");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result dropped or changed while stalled");

  a_sweep_steps: assert property (@(posedge clk) disable iff (rst)
    state == gfr_pkg::ST_CLEAR && !clr_last |=>
      state == gfr_pkg::ST_CLEAR && clr_addr == ADDR_W'($past(clr_addr) + 1'b1))
    else $error("clear sweep skipped or left early");

endmodule

// File: hw/rtl/glyph_framebuffer_renderer_core.sv
// Top level: stream ports, item unpacking, result register, engine and frame store.
//
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------------------------
//  s_axis  | in  | tuser: operation; tdata: x_pos, y_pos, pixel_black, char_code, scale, byte_index
//  m_axis  | out | tdata: read_data
//
// With m_axis ready: a read past the store skips the store read, a set pixel off the frame
// skips its write, clear writes one byte per cycle, and draw character visits each font dot
// and each pixel of a lit dot, writing those on the frame and skipping clipped ones; at
// scale zero nothing is drawn. The single frame store port pair gives one read-modify-write
// per pixel. After reset a white fill of the whole store runs with s_axis_tready low.
// The result register frees the engine while m_axis stalls; a result waits only if it is full.
module glyph_framebuffer_renderer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // x_pos[9:0], y_pos[19:10], pixel_black[20], char_code[28:21], scale[32:29],
  // byte_index[45:33], zero[47:46]
  input  logic [47:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[7:0]
  output logic [7:0]  m_axis_tdata
);

  gfr_pkg::item_t    item;
  gfr_pkg::ram_req_t ram_req;
  logic [7:0]        ram_rdata;
  logic              res_valid;
  logic              res_ready;
  logic [7:0]        res_data;

  // unpack the input beat
  always_comb begin
    item.operation   = gfr_pkg::op_t'(s_axis_tuser);
    item.x_pos       = $signed(s_axis_tdata[9:0]);
    item.y_pos       = $signed(s_axis_tdata[19:10]);
    item.pixel_black = s_axis_tdata[20];
    item.char_code   = s_axis_tdata[28:21];
    item.scale       = s_axis_tdata[32:29];
    item.byte_index  = s_axis_tdata[45:33];
  end

  gfr_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  gfr_frame_ram u_frame_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= res_data;
    end
  end

endmodule
